@@ sv/scid_pkg.sv @@
// ----------------------------------------------------------------------------
// scid_pkg
// Shared types, operation class codes and selector tables for the decoder.
// ----------------------------------------------------------------------------
package scid_pkg;

  localparam int InstrW  = 16;
  localparam int ImmW    = 32;
  localparam int ClassW  = 6;
  localparam int RegW    = 4;
  localparam int SInDataW  = 56;
  localparam int MOutDataW = 48;

  // Instruction groups, bits 15:12.
  localparam logic [3:0] GRP_NOP   = 4'h0;
  localparam logic [3:0] GRP_ALU   = 4'h1;
  localparam logic [3:0] GRP_STORE = 4'h2;
  localparam logic [3:0] GRP_LOAD  = 4'h4;
  localparam logic [3:0] GRP_ALUI  = 4'h5;
  localparam logic [3:0] GRP_ADDI  = 4'h6;
  localparam logic [3:0] GRP_CMPI  = 4'h7;
  localparam logic [3:0] GRP_IMM   = 4'h8;
  localparam logic [3:0] GRP_BRI   = 4'h9;
  localparam logic [3:0] GRP_BRC   = 4'hA;
  localparam logic [3:0] GRP_CALLI = 4'hD;
  localparam logic [3:0] GRP_LIMR  = 4'hE;
  localparam logic [3:0] GRP_RET   = 4'hF;

  // Operation classes.
  localparam logic [ClassW-1:0] CLS_NOP    = 6'd0;
  localparam logic [ClassW-1:0] CLS_ADD    = 6'd1;
  localparam logic [ClassW-1:0] CLS_SRA    = 6'd2;
  localparam logic [ClassW-1:0] CLS_SUB    = 6'd3;
  localparam logic [ClassW-1:0] CLS_AND    = 6'd4;
  localparam logic [ClassW-1:0] CLS_SRL    = 6'd5;
  localparam logic [ClassW-1:0] CLS_OR     = 6'd6;
  localparam logic [ClassW-1:0] CLS_XOR    = 6'd7;
  localparam logic [ClassW-1:0] CLS_COPY   = 6'd8;
  localparam logic [ClassW-1:0] CLS_SHL    = 6'd9;
  localparam logic [ClassW-1:0] CLS_CMP    = 6'd10;
  localparam logic [ClassW-1:0] CLS_STW    = 6'd11;
  localparam logic [ClassW-1:0] CLS_LDW    = 6'd19;
  localparam logic [ClassW-1:0] CLS_ADDI   = 6'd27;
  localparam logic [ClassW-1:0] CLS_CMPI   = 6'd28;
  localparam logic [ClassW-1:0] CLS_IMM    = 6'd29;
  localparam logic [ClassW-1:0] CLS_BRI    = 6'd30;
  localparam logic [ClassW-1:0] CLS_BRIE   = 6'd31;
  localparam logic [ClassW-1:0] CLS_BRINE  = 6'd32;
  localparam logic [ClassW-1:0] CLS_BRIGT  = 6'd33;
  localparam logic [ClassW-1:0] CLS_BRIGE  = 6'd34;
  localparam logic [ClassW-1:0] CLS_BRILT  = 6'd35;
  localparam logic [ClassW-1:0] CLS_BRILE  = 6'd36;
  localparam logic [ClassW-1:0] CLS_BRIUGT = 6'd37;
  localparam logic [ClassW-1:0] CLS_BRIULT = 6'd38;
  localparam logic [ClassW-1:0] CLS_CALLI  = 6'd39;
  localparam logic [ClassW-1:0] CLS_LIMR   = 6'd40;
  localparam logic [ClassW-1:0] CLS_RET    = 6'd41;
  localparam logic [ClassW-1:0] CLS_LAST   = CLS_RET;

  typedef struct packed {
    logic [ClassW-1:0] op_class;
    logic [RegW-1:0]   reg_a;
    logic [RegW-1:0]   reg_b;
    logic              alu_uses_immediate;
    logic [ImmW-1:0]   immediate;
    logic              illegal;
  } decode_t;

  // ALU operation by bits 11:8; NOP marks an undefined selector.
  function automatic logic [ClassW-1:0] alu_class(input logic [3:0] sel);
    logic [ClassW-1:0] cls;
    unique case (sel)
      4'h0:    cls = CLS_ADD;
      4'h3:    cls = CLS_SRA;
      4'h4:    cls = CLS_SUB;
      4'h8:    cls = CLS_AND;
      4'h9:    cls = CLS_SRL;
      4'hA:    cls = CLS_OR;
      4'hB:    cls = CLS_XOR;
      4'hC:    cls = CLS_COPY;
      4'hD:    cls = CLS_CMP;
      4'hF:    cls = CLS_SHL;
      default: cls = CLS_NOP;
    endcase
    return cls;
  endfunction

  // Branch condition by bits 3:0 in the conditional branch group.
  function automatic logic [ClassW-1:0] br_class(input logic [3:0] cond);
    logic [ClassW-1:0] cls;
    unique case (cond)
      4'h0:    cls = CLS_BRI;
      4'h1:    cls = CLS_BRIULT;
      4'h8:    cls = CLS_BRIE;
      4'h9:    cls = CLS_BRINE;
      4'hA:    cls = CLS_BRIGT;
      4'hB:    cls = CLS_BRIGE;
      4'hC:    cls = CLS_BRILT;
      4'hD:    cls = CLS_BRILE;
      4'hE:    cls = CLS_BRIUGT;
      default: cls = CLS_NOP;
    endcase
    return cls;
  endfunction

endpackage

@@ sv/scid_decode.sv @@
// ----------------------------------------------------------------------------
// scid_decode
// Combinational decode of one instruction word into class, registers and
// the formed immediate.
// ----------------------------------------------------------------------------
module scid_decode import scid_pkg::*; (
  input  logic [InstrW-1:0] instr_word,
  input  logic              prefix_pending,
  input  logic [ImmW-1:0]   prefix_value,
  output decode_t           result
);

  logic [3:0]        grp;
  logic [ImmW-1:0]   imm8;
  logic [ImmW-1:0]   imm12;
  logic [ClassW-1:0] cls;
  logic [ClassW-1:0] alu_cls;
  logic [ClassW-1:0] br_cls;
  logic              aluimm;
  logic [ImmW-1:0]   imm;
  logic              bad;

  assign grp     = instr_word[15:12];
  assign alu_cls = alu_class(instr_word[11:8]);
  assign br_cls  = br_class(instr_word[3:0]);

  // With a prefix the pending value is shifted up and the field joined below;
  // otherwise the field is sign-extended from bit 11.
  always_comb begin
    if (prefix_pending) begin
      imm8  = {prefix_value[23:0], instr_word[11:4]};
      imm12 = {prefix_value[19:0], instr_word[11:0]};
    end else begin
      imm8  = {{24{instr_word[11]}}, instr_word[11:4]};
      imm12 = {{20{instr_word[11]}}, instr_word[11:0]};
    end
  end

  always_comb begin
    cls    = CLS_NOP;
    aluimm = 1'b0;
    imm    = '0;
    bad    = 1'b0;
    unique case (grp)
      GRP_NOP:   cls = CLS_NOP;
      GRP_ALU: begin
        cls = alu_cls;
        bad = (alu_cls == CLS_NOP);
      end
      GRP_ALUI: begin
        cls    = alu_cls;
        bad    = (alu_cls == CLS_NOP);
        aluimm = 1'b1;
        imm    = prefix_value;
      end
      GRP_STORE: begin
        cls = CLS_STW + {3'b000, instr_word[10:8]};
        imm = prefix_value;
      end
      GRP_LOAD: begin
        cls = CLS_LDW + {3'b000, instr_word[10:8]};
        imm = prefix_value;
      end
      GRP_ADDI: begin
        cls = CLS_ADDI;
        imm = imm8;
      end
      GRP_CMPI: begin
        cls = CLS_CMPI;
        imm = imm8;
      end
      GRP_IMM: begin
        cls = CLS_IMM;
        imm = imm12;
      end
      GRP_BRI: begin
        cls = CLS_BRI;
        imm = imm8;
      end
      GRP_BRC: begin
        cls = br_cls;
        bad = (br_cls == CLS_NOP);
        imm = imm8;
      end
      GRP_CALLI: begin
        cls = CLS_CALLI;
        imm = imm8;
      end
      GRP_LIMR: begin
        cls = CLS_LIMR;
        imm = imm8;
      end
      GRP_RET:   cls = CLS_RET;
      default:   bad = 1'b1;
    endcase
  end

  // An undefined encoding keeps only the register fields.
  always_comb begin
    result.reg_a              = instr_word[3:0];
    result.reg_b              = instr_word[7:4];
    result.illegal            = bad;
    result.op_class           = bad ? CLS_NOP : cls;
    result.alu_uses_immediate = bad ? 1'b0 : aluimm;
    result.immediate          = bad ? '0 : imm;
  end

endmodule

@@ sv/soft_cpu_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// soft_cpu_instruction_decoder_top
// Streaming wrapper: input register, decode logic, result register.
// ----------------------------------------------------------------------------
// The decoder takes one instruction beat per clock when not stalled and returns
// one result beat per instruction, held first in the input register and then in
// the result register, with the decode logic between them.
// Both registers advance together whenever the result register is empty or
// being drained, so back-pressure on the output side stalls the input side only
// while both stages hold a beat.
module soft_cpu_instruction_decoder_top import scid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // instr_word[15:0], prefix_pending[16], prefix_value[48:17], zero fill
  input  logic [SInDataW-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // op_class[5:0], reg_a[9:6], reg_b[13:10], alu_uses_immediate[14],
  // immediate[46:15], illegal[47]
  output logic [MOutDataW-1:0] m_tdata
);

  logic              in_valid;
  logic [InstrW-1:0] in_instr;
  logic              in_pending;
  logic [ImmW-1:0]   in_prefix;
  logic              out_adv;
  logic              in_adv;
  decode_t           dec;
  decode_t           out_reg;

  assign out_adv  = !m_tvalid || m_tready;
  assign in_adv   = !in_valid || out_adv;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && s_tvalid) begin
      in_instr   <= s_tdata[15:0];
      in_pending <= s_tdata[16];
      in_prefix  <= s_tdata[48:17];
    end
  end

  scid_decode u_decode (
    .instr_word     (in_instr),
    .prefix_pending (in_pending),
    .prefix_value   (in_prefix),
    .result         (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_reg <= dec;
    end
  end

  assign m_tdata = {out_reg.illegal, out_reg.immediate, out_reg.alu_uses_immediate,
                    out_reg.reg_b, out_reg.reg_a, out_reg.op_class};

  // An illegal result carries no class, flag or immediate.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_reg.illegal |->
      out_reg.op_class == CLS_NOP && !out_reg.alu_uses_immediate && out_reg.immediate == '0)
    else $error("illegal result carries decode fields");

  // The immediate-operand flag only goes with an ALU class.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_reg.alu_uses_immediate |->
      out_reg.op_class >= CLS_ADD && out_reg.op_class <= CLS_CMP)
    else $error("ALU immediate flag on a non-ALU class");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_reg.op_class <= CLS_LAST)
    else $error("operation class out of range");

  // A decoded beat moves into the result register on the next edge when that register can advance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && out_adv |=> m_tvalid)
    else $error("decoded beat lost between stages");

  // A stalled result register keeps its beat.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_reg))
    else $error("stalled result dropped");

  // The padding above the input fields is zero on every accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> s_tdata[SInDataW-1:49] == '0)
    else $error("nonzero fill bits on input beat");

endmodule

@@ tb/tb_soft_cpu_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_soft_cpu_instruction_decoder_top
// Self-checking bench for the streaming instruction decoder. A queue-fed
// driver offers instruction beats with random gaps. A monitor compares every
// result beat, field by field, against an in-bench decode of the instruction.
// The receiver stalls at random and once holds off long enough to back up
// the input.
// ----------------------------------------------------------------------------
module tb_soft_cpu_instruction_decoder_top;
  import scid_pkg::*;

  localparam int RandomItems = 500;
  localparam int CycleLimit  = 200000;
  localparam int TailItems   = 40;
  localparam int LongHold    = 100;

  typedef struct packed {
    logic [InstrW-1:0] word;
    logic              pend;
    logic [ImmW-1:0]   pv;
  } instr_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [SInDataW-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [MOutDataW-1:0] m_tdata;

  instr_beat_t pending_instrs[$];
  decode_t     expected_decodes[$];
  instr_beat_t offered_instr;
  int          instrs_accepted = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;
  logic        calm;

  soft_cpu_instruction_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // No idling at the tail of the run, and one stretch without it midway.
  assign calm = (pending_instrs.size() < TailItems) ||
                (instrs_accepted >= 300 && instrs_accepted < 360);

  function automatic decode_t decode_instr(instr_beat_t b);
    decode_t           d;
    logic [ImmW-1:0]   imm8;
    logic [ImmW-1:0]   imm12;
    d = '0;
    d.reg_a = b.word[3:0];
    d.reg_b = b.word[7:4];
    imm8  = b.pend ? {b.pv[23:0], b.word[11:4]} : {{24{b.word[11]}}, b.word[11:4]};
    imm12 = b.pend ? {b.pv[19:0], b.word[11:0]} : {{20{b.word[11]}}, b.word[11:0]};
    case (b.word[15:12])
      GRP_NOP: d.op_class = CLS_NOP;
      GRP_ALU, GRP_ALUI: begin
        case (b.word[11:8])
          4'h0: d.op_class = CLS_ADD;
          4'h3: d.op_class = CLS_SRA;
          4'h4: d.op_class = CLS_SUB;
          4'h8: d.op_class = CLS_AND;
          4'h9: d.op_class = CLS_SRL;
          4'hA: d.op_class = CLS_OR;
          4'hB: d.op_class = CLS_XOR;
          4'hC: d.op_class = CLS_COPY;
          4'hD: d.op_class = CLS_CMP;
          4'hF: d.op_class = CLS_SHL;
          default: d.illegal = 1'b1;
        endcase
        if (!d.illegal && b.word[15:12] == GRP_ALUI) begin
          d.alu_uses_immediate = 1'b1;
          d.immediate = b.pv;
        end
      end
      // Bit 11 plays no part in loads and stores.
      GRP_STORE: begin
        d.op_class = CLS_STW + ClassW'(b.word[10:8]);
        d.immediate = b.pv;
      end
      GRP_LOAD: begin
        d.op_class = CLS_LDW + ClassW'(b.word[10:8]);
        d.immediate = b.pv;
      end
      GRP_ADDI: begin
        d.op_class = CLS_ADDI;
        d.immediate = imm8;
      end
      GRP_CMPI: begin
        d.op_class = CLS_CMPI;
        d.immediate = imm8;
      end
      GRP_IMM: begin
        d.op_class = CLS_IMM;
        d.immediate = imm12;
      end
      GRP_BRI: begin
        d.op_class = CLS_BRI;
        d.immediate = imm8;
      end
      GRP_BRC: begin
        case (b.word[3:0])
          4'h0: d.op_class = CLS_BRI;
          4'h1: d.op_class = CLS_BRIULT;
          4'h8: d.op_class = CLS_BRIE;
          4'h9: d.op_class = CLS_BRINE;
          4'hA: d.op_class = CLS_BRIGT;
          4'hB: d.op_class = CLS_BRIGE;
          4'hC: d.op_class = CLS_BRILT;
          4'hD: d.op_class = CLS_BRILE;
          4'hE: d.op_class = CLS_BRIUGT;
          default: d.illegal = 1'b1;
        endcase
        if (!d.illegal) d.immediate = imm8;
      end
      GRP_CALLI: begin
        d.op_class = CLS_CALLI;
        d.immediate = imm8;
      end
      GRP_LIMR: begin
        d.op_class = CLS_LIMR;
        d.immediate = imm8;
      end
      GRP_RET: d.op_class = CLS_RET;
      default: d.illegal = 1'b1;
    endcase
    return d;
  endfunction

  function automatic string show_decode(decode_t d);
    return $sformatf("cls=%0d a=%h b=%h aluimm=%b imm=%h illegal=%b", d.op_class,
                     d.reg_a, d.reg_b, d.alu_uses_immediate, d.immediate, d.illegal);
  endfunction

  task automatic add_instr(logic [InstrW-1:0] word, logic pend, logic [ImmW-1:0] pv);
    instr_beat_t b;
    b.word = word;
    b.pend = pend;
    b.pv   = pv;
    pending_instrs.push_back(b);
  endtask

  // Sender: predicts each accepted beat and offers the next one from the queue.
  always @(posedge clk) begin : driver
    instr_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_decodes.push_back(decode_instr(offered_instr));
        instrs_accepted <= instrs_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_instrs.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (!calm && hold_left == 0 && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 13) - 1;
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_instrs.pop_front();
          offered_instr <= nxt;
          s_tdata  <= {{(SInDataW - InstrW - 1 - ImmW){1'b0}}, nxt.pv, nxt.pend, nxt.word};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to fill the pipeline.
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && instrs_accepted >= 150) begin
      hold_done <= 1'b1;
      hold_left <= LongHold - 1;
      m_tready  <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      recv_stall <= $urandom_range(1, 13) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    decode_t got;
    decode_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.op_class           = m_tdata[5:0];
      got.reg_a              = m_tdata[9:6];
      got.reg_b              = m_tdata[13:10];
      got.alu_uses_immediate = m_tdata[14];
      got.immediate          = m_tdata[46:15];
      got.illegal            = m_tdata[47];
      if (expected_decodes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat: %s", show_decode(got));
      end else begin
        want = expected_decodes.pop_front();
        if (got.op_class !== want.op_class || got.reg_a !== want.reg_a ||
            got.reg_b !== want.reg_b ||
            got.alu_uses_immediate !== want.alu_uses_immediate ||
            got.immediate !== want.immediate || got.illegal !== want.illegal) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: expected %s, got %s", show_decode(want),
                     show_decode(got));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("soft_cpu_instruction_decoder_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    logic [ImmW-1:0] pv;
    // Extremes of every group, sign and prefix forms, and the undefined encodings.
    add_instr(16'h0000, 1'b0, 32'h0000_0000);
    add_instr(16'hF000, 1'b1, 32'hFFFF_FFFF);
    add_instr(16'h0FFF, 1'b1, 32'h1234_5678);
    add_instr(16'h1000, 1'b0, 32'hFFFF_FFFF);
    add_instr(16'h1FFF, 1'b1, 32'h0000_0001);
    add_instr(16'h1E5A, 1'b0, 32'hAAAA_5555);
    add_instr(16'h5D00, 1'b0, 32'hFFFF_FFFF);
    add_instr(16'h5100, 1'b1, 32'hDEAD_BEEF);
    add_instr(16'h2000, 1'b0, 32'h0000_0001);
    add_instr(16'h2F12, 1'b1, 32'h8000_0000);
    add_instr(16'h4800, 1'b1, 32'h8000_0000);
    add_instr(16'h47FF, 1'b0, 32'h7FFF_FFFF);
    add_instr(16'h6800, 1'b0, 32'h0000_0000);
    add_instr(16'h67F0, 1'b0, 32'hFFFF_FFFF);
    add_instr(16'h7FF5, 1'b1, 32'hFFFF_FFFF);
    add_instr(16'h8800, 1'b0, 32'h0000_0000);
    add_instr(16'h87FF, 1'b0, 32'hFFFF_FFFF);
    add_instr(16'h8FFF, 1'b1, 32'hFFFF_FFFF);
    add_instr(16'h9AB0, 1'b0, 32'h0000_0000);
    add_instr(16'hA00F, 1'b1, 32'h5555_AAAA);
    add_instr(16'hA001, 1'b0, 32'h0000_0000);
    add_instr(16'hA8FE, 1'b1, 32'h00FF_FF00);
    add_instr(16'hD880, 1'b0, 32'h0000_0000);
    add_instr(16'hE7FF, 1'b1, 32'h000F_FFFF);
    add_instr(16'h3FFF, 1'b1, 32'hFFFF_FFFF);
    add_instr(16'hB000, 1'b0, 32'h0000_0000);
    add_instr(16'hC123, 1'b1, 32'h0F0F_0F0F);
    for (i = 0; i < RandomItems; i++) begin
      case ($urandom_range(0, 7))
        0:       pv = 32'h0000_0000;
        1:       pv = 32'hFFFF_FFFF;
        default: pv = $urandom;
      endcase
      add_instr(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), pv);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_instrs.size() != 0 || s_tvalid || expected_decodes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0)
      $display("soft_cpu_instruction_decoder_top verification clean");
    else
      $display("soft_cpu_instruction_decoder_top verification failed");
    $finish;
  end

endmodule
